### hw/rtl/lwpcs_pkg.sv
`default_nettype none

package lwpcs_pkg;

    // Opcodes of a command item.
    localparam logic [2:0] OP_WINDOW  = 3'd0;
    localparam logic [2:0] OP_PIXEL   = 3'd1;
    localparam logic [2:0] OP_ORIENT  = 3'd2;
    localparam logic [2:0] OP_DISPLAY = 3'd3;
    localparam logic [2:0] OP_INVERT  = 3'd4;

    // Panel controller command codes.
    localparam logic [7:0] CMD_COLUMN   = 8'h2A;
    localparam logic [7:0] CMD_ROW      = 8'h2B;
    localparam logic [7:0] CMD_MEMWRITE = 8'h2C;
    localparam logic [7:0] CMD_MODE     = 8'h36;
    localparam logic [7:0] CMD_DISP_ON  = 8'h29;
    localparam logic [7:0] CMD_DISP_OFF = 8'h28;
    localparam logic [7:0] CMD_INV_ON   = 8'h21;
    localparam logic [7:0] CMD_INV_OFF  = 8'h20;

    // Memory access control bits of the orientation mode byte.
    localparam logic [7:0] MODE_ROW_FLIP = 8'h80;
    localparam logic [7:0] MODE_COL_FLIP = 8'h40;
    localparam logic [7:0] MODE_SWAP     = 8'h20;

    localparam int unsigned COUNT_W = 15;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 15'h7FFF;

    // Byte positions inside a window job.
    localparam logic [3:0] WIN_LAST_IDX = 4'd10;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [15:0] x_start;
        logic [15:0] y_start;
        logic [15:0] rect_width;
        logic [15:0] rect_height;
        logic [15:0] pixel_color;
        logic [2:0]  new_orientation;
        logic        enable;
    } cmd_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_data;
        logic       last_of_run;
        logic       window_complete;
    } tx_item_t;

    typedef enum logic [1:0] {
        KIND_WINDOW = 2'd0,
        KIND_PIXEL  = 2'd1,
        KIND_MODE   = 2'd2,
        KIND_SINGLE = 2'd3
    } job_kind_t;

    // A job is one classified command waiting to be serialized.
    // Window: a0..a3 are column start/end and row start/end.
    // Pixel: a0 is the color, done marks the window's final pixel.
    // Mode and single commands: a0[7:0] is the mode byte or command code.
    typedef struct packed {
        job_kind_t   kind;
        logic [15:0] a0;
        logic [15:0] a1;
        logic [15:0] a2;
        logic [15:0] a3;
        logic        done;
    } job_t;

    function automatic logic [7:0] mode_byte(input logic [1:0] orient);
        logic [7:0] value;
        unique case (orient)
            2'd0:    value = MODE_COL_FLIP | MODE_ROW_FLIP;
            2'd1:    value = MODE_COL_FLIP | MODE_SWAP;
            2'd2:    value = 8'h00;
            default: value = MODE_ROW_FLIP | MODE_SWAP;
        endcase
        return value;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/lwpcs_front.sv
`default_nettype none

module lwpcs_front #(
    parameter int PANEL_WIDTH  = 128,
    parameter int PANEL_HEIGHT = 160
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   cmd_valid,
    output logic                  cmd_ready,
    input  lwpcs_pkg::cmd_item_t  cmd_item,
    output logic                  push,
    output lwpcs_pkg::job_t       push_job,
    input  wire                   q_full
);
    import lwpcs_pkg::*;

    localparam int DIM_MAX = (PANEL_WIDTH > PANEL_HEIGHT) ? PANEL_WIDTH : PANEL_HEIGHT;
    localparam int DIM_W   = $clog2(DIM_MAX + 3);
    localparam int EXT_W   = (2 * DIM_W > COUNT_W) ? 2 * DIM_W : COUNT_W + 1;

    logic [1:0]         orient_reg, orient_next;
    logic [COUNT_W-1:0] left_reg, left_next;
    logic               busy_reg, busy_next;
    logic [DIM_W-1:0]   win_x_reg, win_x_next;
    logic [DIM_W-1:0]   win_y_reg, win_y_next;
    logic [DIM_W-1:0]   win_w_reg, win_w_next;
    logic [DIM_W-1:0]   win_h_reg, win_h_next;
    logic               win_swap_reg, win_swap_next;

    logic               accept;
    logic               swapped;
    logic               off_screen;
    logic [DIM_W-1:0]   pw, ph, rem_w, rem_h, w_clip, h_clip;
    logic [DIM_W-1:0]   col_start, col_end, row_start, row_end;
    logic [EXT_W-1:0]   area;
    logic [COUNT_W-1:0] area_sat;
    logic               a_push;
    job_t               a_job, win_job;

    assign cmd_ready = !busy_reg && !q_full;
    assign accept    = cmd_valid && cmd_ready;

    // Window accept: reject empty or off-screen windows and clip to the panel edge.
    assign swapped    = orient_reg[0];
    assign pw         = swapped ? DIM_W'(PANEL_HEIGHT) : DIM_W'(PANEL_WIDTH);
    assign ph         = swapped ? DIM_W'(PANEL_WIDTH) : DIM_W'(PANEL_HEIGHT);
    assign off_screen = (cmd_item.x_start >= 16'(pw)) || (cmd_item.y_start >= 16'(ph))
                        || (cmd_item.rect_width == 16'd0) || (cmd_item.rect_height == 16'd0);
    assign rem_w      = pw - cmd_item.x_start[DIM_W-1:0];
    assign rem_h      = ph - cmd_item.y_start[DIM_W-1:0];
    assign w_clip     = (cmd_item.rect_width >= 16'(rem_w)) ? rem_w
                                                           : cmd_item.rect_width[DIM_W-1:0];
    assign h_clip     = (cmd_item.rect_height >= 16'(rem_h)) ? rem_h
                                                            : cmd_item.rect_height[DIM_W-1:0];

    // Window busy step: offset addresses and the saturated pixel count.
    assign col_start = win_x_reg + (win_swap_reg ? DIM_W'(1) : DIM_W'(2));
    assign col_end   = win_x_reg + win_w_reg + (win_swap_reg ? DIM_W'(0) : DIM_W'(1));
    assign row_start = win_y_reg + (win_swap_reg ? DIM_W'(2) : DIM_W'(1));
    assign row_end   = win_y_reg + win_h_reg + (win_swap_reg ? DIM_W'(1) : DIM_W'(0));
    assign area      = EXT_W'(win_w_reg) * EXT_W'(win_h_reg);
    assign area_sat  = (area > EXT_W'(COUNT_MAX)) ? COUNT_MAX : area[COUNT_W-1:0];

    always_comb
    begin
        win_job      = '0;
        win_job.kind = KIND_WINDOW;
        win_job.a0   = 16'(col_start);
        win_job.a1   = 16'(col_end);
        win_job.a2   = 16'(row_start);
        win_job.a3   = 16'(row_end);
    end

    always_comb
    begin
        a_push        = 1'b0;
        a_job         = '0;
        a_job.kind    = KIND_SINGLE;
        orient_next   = orient_reg;
        left_next     = left_reg;
        busy_next     = busy_reg;
        win_x_next    = win_x_reg;
        win_y_next    = win_y_reg;
        win_w_next    = win_w_reg;
        win_h_next    = win_h_reg;
        win_swap_next = win_swap_reg;

        if (busy_reg)
        begin
            if (!q_full)
            begin
                busy_next = 1'b0;
                left_next = area_sat;
            end
        end
        else if (accept)
        begin
            unique case (cmd_item.opcode)
                OP_WINDOW:
                begin
                    if (!off_screen)
                    begin
                        busy_next     = 1'b1;
                        win_x_next    = cmd_item.x_start[DIM_W-1:0];
                        win_y_next    = cmd_item.y_start[DIM_W-1:0];
                        win_w_next    = w_clip;
                        win_h_next    = h_clip;
                        win_swap_next = swapped;
                    end
                end
                OP_PIXEL:
                begin
                    if (left_reg != '0)
                    begin
                        a_push     = 1'b1;
                        a_job.kind = KIND_PIXEL;
                        a_job.a0   = cmd_item.pixel_color;
                        a_job.done = (left_reg == COUNT_W'(1));
                        left_next  = left_reg - COUNT_W'(1);
                    end
                end
                OP_ORIENT:
                begin
                    if (cmd_item.new_orientation[2] == 1'b0)
                    begin
                        a_push      = 1'b1;
                        a_job.kind  = KIND_MODE;
                        a_job.a0    = {8'h00, mode_byte(cmd_item.new_orientation[1:0])};
                        orient_next = cmd_item.new_orientation[1:0];
                    end
                end
                OP_DISPLAY:
                begin
                    a_push   = 1'b1;
                    a_job.a0 = {8'h00, cmd_item.enable ? CMD_DISP_ON : CMD_DISP_OFF};
                end
                OP_INVERT:
                begin
                    a_push   = 1'b1;
                    a_job.a0 = {8'h00, cmd_item.enable ? CMD_INV_ON : CMD_INV_OFF};
                end
                default:
                begin
                    a_push = 1'b0;
                end
            endcase
        end
    end

    assign push     = busy_reg ? !q_full : a_push;
    assign push_job = busy_reg ? win_job : a_job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            orient_reg <= 2'd0;
            left_reg   <= '0;
            busy_reg   <= 1'b0;
        end
        else
        begin
            orient_reg <= orient_next;
            left_reg   <= left_next;
            busy_reg   <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_x_reg    <= win_x_next;
        win_y_reg    <= win_y_next;
        win_w_reg    <= win_w_next;
        win_h_reg    <= win_h_next;
        win_swap_reg <= win_swap_next;
    end

endmodule

`default_nettype wire

### hw/rtl/lwpcs_queue.sv
`default_nettype none

module lwpcs_queue #(
    parameter int DEPTH = 4
) (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              push,
    input  lwpcs_pkg::job_t  push_job,
    output logic             full,
    input  wire              pop,
    output lwpcs_pkg::job_t  head_job,
    output logic             head_valid
);
    import lwpcs_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/lwpcs_back.sv
`default_nettype none

module lwpcs_back (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  head_valid,
    input  lwpcs_pkg::job_t      head_job,
    output logic                 pop,
    output logic                 tx_valid,
    input  wire                  tx_ready,
    output lwpcs_pkg::tx_item_t  tx_item
);
    import lwpcs_pkg::*;

    logic       cur_valid_reg, cur_valid_next;
    job_t       cur_job_reg, cur_job_next;
    logic [3:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    tx_item_t   out_item_reg, out_item_next;

    logic       advance;
    logic       cur_last;
    logic [3:0] last_idx;
    tx_item_t   byte_item;

    always_comb
    begin
        unique case (cur_job_reg.kind)
            KIND_WINDOW: last_idx = WIN_LAST_IDX;
            KIND_PIXEL:  last_idx = 4'd1;
            KIND_MODE:   last_idx = 4'd1;
            default:     last_idx = 4'd0;
        endcase
    end

    assign cur_last = (idx_reg == last_idx);
    assign advance  = cur_valid_reg && (!out_valid_reg || tx_ready);
    assign pop      = head_valid && (!cur_valid_reg || (advance && cur_last));

    // Byte selection for the current job position.
    always_comb
    begin
        byte_item                 = '0;
        byte_item.last_of_run     = cur_last;
        unique case (cur_job_reg.kind)
            KIND_WINDOW:
            begin
                byte_item.is_data = 1'b1;
                unique case (idx_reg)
                    4'd0:
                    begin
                        byte_item.out_byte = CMD_COLUMN;
                        byte_item.is_data  = 1'b0;
                    end
                    4'd1: byte_item.out_byte = cur_job_reg.a0[15:8];
                    4'd2: byte_item.out_byte = cur_job_reg.a0[7:0];
                    4'd3: byte_item.out_byte = cur_job_reg.a1[15:8];
                    4'd4: byte_item.out_byte = cur_job_reg.a1[7:0];
                    4'd5:
                    begin
                        byte_item.out_byte = CMD_ROW;
                        byte_item.is_data  = 1'b0;
                    end
                    4'd6: byte_item.out_byte = cur_job_reg.a2[15:8];
                    4'd7: byte_item.out_byte = cur_job_reg.a2[7:0];
                    4'd8: byte_item.out_byte = cur_job_reg.a3[15:8];
                    4'd9: byte_item.out_byte = cur_job_reg.a3[7:0];
                    default:
                    begin
                        byte_item.out_byte = CMD_MEMWRITE;
                        byte_item.is_data  = 1'b0;
                    end
                endcase
            end
            KIND_PIXEL:
            begin
                byte_item.is_data = 1'b1;
                if (idx_reg == 4'd0)
                begin
                    byte_item.out_byte = cur_job_reg.a0[15:8];
                end
                else
                begin
                    byte_item.out_byte        = cur_job_reg.a0[7:0];
                    byte_item.window_complete = cur_job_reg.done;
                end
            end
            KIND_MODE:
            begin
                if (idx_reg == 4'd0)
                begin
                    byte_item.out_byte = CMD_MODE;
                    byte_item.is_data  = 1'b0;
                end
                else
                begin
                    byte_item.out_byte = cur_job_reg.a0[7:0];
                    byte_item.is_data  = 1'b1;
                end
            end
            default:
            begin
                byte_item.out_byte = cur_job_reg.a0[7:0];
                byte_item.is_data  = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        cur_job_next   = cur_job_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;

        if (pop)
        begin
            cur_valid_next = 1'b1;
            cur_job_next   = head_job;
            idx_next       = 4'd0;
        end
        else if (advance)
        begin
            if (cur_last)
            begin
                cur_valid_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + 4'd1;
            end
        end

        if (advance)
        begin
            out_valid_next = 1'b1;
            out_item_next  = byte_item;
        end
        else if (tx_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_job_reg  <= cur_job_next;
        out_item_reg <= out_item_next;
    end

    assign tx_valid = out_valid_reg;
    assign tx_item  = out_item_reg;

endmodule

`default_nettype wire

### hw/rtl/lcd_window_pixel_command_stream_unit.sv
// Command to byte stream converter for an SPI panel controller with a
// command/data select line.
// The cmd channel (cmd_valid, cmd_ready, cmd_item) takes display commands:
// open window, pixel, set orientation, display on/off and invert on/off.
// The tx channel (tx_valid, tx_ready, tx_item) delivers one byte per item
// with its command/data flag, an end-of-run mark and a window-complete mark.
// A front section classifies each command, clips windows and keeps the
// orientation and the pixel countdown; a job queue of QUEUE_DEPTH entries
// feeds a back section that serializes jobs into the output register.
// The first byte of a pixel, orientation or on/off item passes the queue,
// the back section's job register and the output register; that of a
// window first passes the front's window registers too. Throughput: while
// the receiver is ready, the back section sends one byte per cycle; pixel
// items are two bytes each. An open window is clipped, then holds the
// front while it multiplies for the pixel count, and produces eleven bytes.
// Reset clears orientation to zero degrees, closes any window, and empties
// the queue and the output register.
// When the receiver stalls, the output register holds its byte, the queue
// fills up and cmd_ready falls; no byte is lost or repeated.
`default_nettype none

module lcd_window_pixel_command_stream_unit #(
    parameter int PANEL_WIDTH  = 128,
    parameter int PANEL_HEIGHT = 160,
    parameter int QUEUE_DEPTH  = 4
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  cmd_valid,
    output logic                 cmd_ready,
    input  lwpcs_pkg::cmd_item_t cmd_item,
    output logic                 tx_valid,
    input  wire                  tx_ready,
    output lwpcs_pkg::tx_item_t  tx_item
);
    import lwpcs_pkg::*;

    logic push;
    job_t push_job;
    logic q_full;
    logic pop;
    job_t head_job;
    logic head_valid;

    // Front: accepts commands and turns them into jobs.
    lwpcs_front #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_item  (cmd_item),
        .push      (push),
        .push_job  (push_job),
        .q_full    (q_full)
    );

    // Queue: decouples the front from output stalls.
    lwpcs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (q_full),
        .pop        (pop),
        .head_job   (head_job),
        .head_valid (head_valid)
    );

    // Back: walks each job one byte per cycle into the output register while the receiver is ready.
    lwpcs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .tx_valid   (tx_valid),
        .tx_ready   (tx_ready),
        .tx_item    (tx_item)
    );

endmodule

`default_nettype wire

### hw/rtl/lwpcs_checker.sv
`default_nettype none

module lwpcs_checker (
    input wire                  clk,
    input wire                  rst_n,
    input wire                  cmd_valid,
    input wire                  cmd_ready,
    input lwpcs_pkg::cmd_item_t cmd_item,
    input wire                  tx_valid,
    input wire                  tx_ready,
    input lwpcs_pkg::tx_item_t  tx_item
);
    import lwpcs_pkg::*;

    logic cmd_seen;

    assign cmd_seen = cmd_valid && cmd_ready && (cmd_item.opcode == OP_WINDOW);

    // A stalled byte stays on the port unchanged.
    a_tx_hold: assert property (@(posedge clk) disable iff (!rst_n)
        tx_valid && !tx_ready |=> tx_valid && $stable(tx_item))
        else $error("tx item changed while stalled");

    // Window completion only marks the last data byte of a pixel.
    a_wc_shape: assert property (@(posedge clk) disable iff (!rst_n)
        tx_valid && tx_item.window_complete |-> tx_item.is_data && tx_item.last_of_run)
        else $error("window_complete on a byte that cannot end a window");

    // A command byte that does not end its run must open a longer sequence.
    a_cmd_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        tx_valid && !tx_item.is_data && !tx_item.last_of_run |->
            (tx_item.out_byte == CMD_COLUMN) || (tx_item.out_byte == CMD_ROW)
            || (tx_item.out_byte == CMD_MODE))
        else $error("unexpected command byte inside a run");

    // A non-empty window that starts at the origin is always on screen, so the
    // front goes busy with it and ready drops right after it.
    a_window_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_seen && (cmd_item.x_start == 16'd0) && (cmd_item.y_start == 16'd0)
        && (cmd_item.rect_width != 16'd0) && (cmd_item.rect_height != 16'd0)
        |=> !cmd_ready)
        else $error("cmd_ready stayed high after an open window");

endmodule

bind lcd_window_pixel_command_stream_unit lwpcs_checker u_lwpcs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd_item  (cmd_item),
    .tx_valid  (tx_valid),
    .tx_ready  (tx_ready),
    .tx_item   (tx_item)
);

`default_nettype wire
